[src/cpu65_pkg.sv]
// Package: shared constants, decode table and flag helpers for the 6502 subset executor.
`timescale 1ns / 1ps
package cpu65_pkg;

    localparam int ADDR_BITS = 16;

    // Request codes
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_EXEC  = 2'd1;
    localparam logic [1:0] REQ_RESET = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    // Special addresses
    localparam logic [15:0] PRINT_ADDR = 16'hFFFB;
    localparam logic [15:0] VEC_LO     = 16'hFFFC;
    localparam logic [15:0] VEC_HI     = 16'hFFFD;
    localparam logic [7:0]  STACK_PAGE = 8'h01;
    localparam logic [15:0] RV_RESET   = 16'h8000;
    localparam logic [7:0]  SP_RESET   = 8'hFD;

    // Flag bits
    localparam int FN = 7;
    localparam int FZ = 1;
    localparam int FC = 0;
    localparam logic [7:0] F_B      = 8'h10;
    localparam logic [7:0] F_PUSH   = 8'h30;
    localparam logic [7:0] F_PULLMK = 8'hCF;

    // Opcodes examined outside the decode table
    localparam logic [7:0] OP_TAX = 8'hAA;
    localparam logic [7:0] OP_TAY = 8'hA8;
    localparam logic [7:0] OP_TSX = 8'hBA;
    localparam logic [7:0] OP_TXA = 8'h8A;
    localparam logic [7:0] OP_TXS = 8'h9A;
    localparam logic [7:0] OP_TYA = 8'h98;
    localparam logic [7:0] OP_ASLA = 8'h0A;
    localparam logic [7:0] OP_LSRA = 8'h4A;
    localparam logic [7:0] OP_PLA = 8'h68;
    localparam logic [7:0] OP_PLP = 8'h28;
    localparam logic [7:0] OP_RTS = 8'h60;
    localparam logic [7:0] OP_RTI = 8'h40;

    // Instruction classes
    localparam logic [3:0] C_NOP  = 4'd0;
    localparam logic [3:0] C_UNK  = 4'd1;
    localparam logic [3:0] C_BRK  = 4'd2;
    localparam logic [3:0] C_IMM  = 4'd3;
    localparam logic [3:0] C_TR   = 4'd4;
    localparam logic [3:0] C_LD   = 4'd5;
    localparam logic [3:0] C_ST   = 4'd6;
    localparam logic [3:0] C_RMW  = 4'd7;
    localparam logic [3:0] C_PUSH = 4'd8;
    localparam logic [3:0] C_PULL = 4'd9;
    localparam logic [3:0] C_JMP  = 4'd10;
    localparam logic [3:0] C_JMPI = 4'd11;
    localparam logic [3:0] C_JSR  = 4'd12;

    // Addressing modes
    localparam logic [2:0] M_ZP  = 3'd0;
    localparam logic [2:0] M_ZPX = 3'd1;
    localparam logic [2:0] M_IZX = 3'd2;
    localparam logic [2:0] M_IZY = 3'd3;
    localparam logic [2:0] M_ABS = 3'd4;
    localparam logic [2:0] M_ABX = 3'd5;
    localparam logic [2:0] M_ABY = 3'd6;

    // Register selects
    localparam logic [1:0] R_A = 2'd0;
    localparam logic [1:0] R_X = 2'd1;
    localparam logic [1:0] R_Y = 2'd2;

    typedef struct packed {
        logic [3:0] cls;
        logic [2:0] mode;
        logic [1:0] rsel;
        logic       is_and;
        logic [1:0] len;
    } t_dec;

    function automatic t_dec mk(input logic [3:0] c, input logic [2:0] m,
                                input logic [1:0] r, input logic a,
                                input logic [1:0] l);
        t_dec d;
        d.cls = c; d.mode = m; d.rsel = r; d.is_and = a; d.len = l;
        return d;
    endfunction

    // Opcode decode table
    function automatic t_dec f_dec(input logic [7:0] op);
        t_dec d;
        case (op)
            8'h00: d = mk(C_BRK, M_ZP, R_A, 1'b0, 2'd1);
            8'hA9: d = mk(C_IMM, M_ZP, R_A, 1'b0, 2'd2);
            8'hA5: d = mk(C_LD, M_ZP, R_A, 1'b0, 2'd2);
            8'hB5: d = mk(C_LD, M_ZPX, R_A, 1'b0, 2'd2);
            8'hA1: d = mk(C_LD, M_IZX, R_A, 1'b0, 2'd2);
            8'hB1: d = mk(C_LD, M_IZY, R_A, 1'b0, 2'd2);
            8'hAD: d = mk(C_LD, M_ABS, R_A, 1'b0, 2'd3);
            8'hBD: d = mk(C_LD, M_ABX, R_A, 1'b0, 2'd3);
            8'hB9: d = mk(C_LD, M_ABY, R_A, 1'b0, 2'd3);
            8'hA2: d = mk(C_IMM, M_ZP, R_X, 1'b0, 2'd2);
            8'hA6: d = mk(C_LD, M_ZP, R_X, 1'b0, 2'd2);
            8'hAE: d = mk(C_LD, M_ABS, R_X, 1'b0, 2'd3);
            8'hA0: d = mk(C_IMM, M_ZP, R_Y, 1'b0, 2'd2);
            8'hA4: d = mk(C_LD, M_ZP, R_Y, 1'b0, 2'd2);
            8'hAC: d = mk(C_LD, M_ABS, R_Y, 1'b0, 2'd3);
            8'h85: d = mk(C_ST, M_ZP, R_A, 1'b0, 2'd2);
            8'h95: d = mk(C_ST, M_ZPX, R_A, 1'b0, 2'd2);
            8'h81: d = mk(C_ST, M_IZX, R_A, 1'b0, 2'd2);
            8'h91: d = mk(C_ST, M_IZY, R_A, 1'b0, 2'd2);
            8'h8D: d = mk(C_ST, M_ABS, R_A, 1'b0, 2'd3);
            8'h86: d = mk(C_ST, M_ZP, R_X, 1'b0, 2'd2);
            8'h8E: d = mk(C_ST, M_ABS, R_X, 1'b0, 2'd3);
            8'h84: d = mk(C_ST, M_ZP, R_Y, 1'b0, 2'd2);
            8'h8C: d = mk(C_ST, M_ABS, R_Y, 1'b0, 2'd3);
            8'hAA, 8'hA8, 8'hBA, 8'h8A, 8'h9A, 8'h98, 8'h0A, 8'h4A:
                d = mk(C_TR, M_ZP, R_A, 1'b0, 2'd1);
            8'h48, 8'h08: d = mk(C_PUSH, M_ZP, R_A, 1'b0, 2'd1);
            8'h68, 8'h28, 8'h60, 8'h40: d = mk(C_PULL, M_ZP, R_A, 1'b0, 2'd1);
            8'h06, 8'h46: d = mk(C_RMW, M_ZP, R_A, 1'b0, 2'd2);
            8'h0E, 8'h4E: d = mk(C_RMW, M_ABS, R_A, 1'b0, 2'd3);
            8'h29: d = mk(C_IMM, M_ZP, R_A, 1'b1, 2'd2);
            8'h25: d = mk(C_LD, M_ZP, R_A, 1'b1, 2'd2);
            8'h2D: d = mk(C_LD, M_ABS, R_A, 1'b1, 2'd3);
            8'h4C: d = mk(C_JMP, M_ABS, R_A, 1'b0, 2'd3);
            8'h6C: d = mk(C_JMPI, M_ABS, R_A, 1'b0, 2'd3);
            8'h20: d = mk(C_JSR, M_ABS, R_A, 1'b0, 2'd3);
            8'hEA: d = mk(C_NOP, M_ZP, R_A, 1'b0, 2'd1);
            default: d = mk(C_UNK, M_ZP, R_A, 1'b0, 2'd1);
        endcase
        return d;
    endfunction

    // Update N and Z from a result byte
    function automatic logic [7:0] f_nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] r;
        r = p;
        r[FN] = v[7];
        r[FZ] = (v == 8'h00);
        return r;
    endfunction

endpackage

[src/cpu65_ram.sv]
// Single-port byte RAM with registered read.
`timescale 1ns / 1ps
module cpu65_ram #(
    parameter int AW = 16,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [DW-1:0] i_wdata,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] mem [0:(1<<AW)-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        o_rdata <= mem[i_addr];
    end
endmodule

[src/cpu6502_subset_executor.sv]
// Top level: request sequencer and register file of the 6502 subset executor.
`timescale 1ns / 1ps
// Usage:
//   Input channel (i_valid / o_ready) carries one request item: load a byte,
//   execute one instruction, reset the core, or read a byte. Every item gives
//   exactly one result item on the output channel (o_valid / i_ready) with the
//   register state after the request, the read byte and an unknown-op flag.
//   The reset vector is to be written through i_cfg_we / i_cfg_data only
//   while idle; the block does not enforce this. All state lives in one
//   single-port 64 KiB RAM plus the CPU registers; the sequencer makes one RAM
//   access per cycle and read data returns in the next cycle. An item holds
//   the sequencer until its result is registered: a read waits for its byte,
//   an instruction fetches three bytes, decodes and executes, and memory
//   operands (the indirect modes most), pulls, indirect JMP and JSR add states.
//   A new item is accepted the cycle after a result is registered, even if
//   the receiver has not yet taken it; a result that cannot be registered
//   because the previous one still waits holds the sequencer.
//   Synchronous reset (i_rst_n low) sets the reset vector and PC to 0x8000,
//   SP to 0xFD, A, X, Y, P to 0; RAM contents are undefined until written.
module cpu6502_subset_executor
    import cpu65_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_mem_address,
    input  logic [7:0]  i_mem_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_pc_out,
    output logic [7:0]  o_acc_out,
    output logic [7:0]  o_x_out,
    output logic [7:0]  o_y_out,
    output logic [7:0]  o_sp_out,
    output logic [7:0]  o_status_out,
    output logic [7:0]  o_read_byte,
    output logic        o_unknown_op
);
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_B1   = 5'd1;
    localparam logic [4:0] S_B2   = 5'd2;
    localparam logic [4:0] S_DEC  = 5'd3;
    localparam logic [4:0] S_EX   = 5'd4;
    localparam logic [4:0] S_PL   = 5'd5;
    localparam logic [4:0] S_PH   = 5'd6;
    localparam logic [4:0] S_ACC  = 5'd7;
    localparam logic [4:0] S_MEM  = 5'd8;
    localparam logic [4:0] S_WB   = 5'd9;
    localparam logic [4:0] S_POP1 = 5'd10;
    localparam logic [4:0] S_POP2 = 5'd11;
    localparam logic [4:0] S_POP3 = 5'd12;
    localparam logic [4:0] S_JI1  = 5'd13;
    localparam logic [4:0] S_JI2  = 5'd14;
    localparam logic [4:0] S_JSR2 = 5'd15;
    localparam logic [4:0] S_RDR  = 5'd16;
    localparam logic [4:0] S_OUT  = 5'd17;

    logic [4:0]  r_state, n_state;
    logic [15:0] r_rv;
    logic [15:0] r_pc, n_pc;
    logic [7:0]  r_a, n_a, r_x, n_x, r_y, n_y, r_sp, n_sp, r_p, n_p;
    logic [7:0]  r_op, n_op, r_b1, n_b1, r_b2, n_b2, r_lo, n_lo, r_wd, n_wd;
    logic [7:0]  r_zp, n_zp, r_rb, n_rb;
    logic        r_unk, n_unk;
    logic [15:0] r_ea, n_ea, r_ra, n_ra;
    logic        r_ov;

    logic        mem_we;
    logic [15:0] mem_addr;
    logic [7:0]  mem_wd, mem_q, rd_val;
    logic        wr_req;
    t_dec        d;
    logic [15:0] ab, ea, t_ret;
    logic [7:0]  v, res, src;

    cpu65_ram #(.AW(ADDR_BITS), .DW(8)) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_addr (mem_addr[ADDR_BITS-1:0]),
        .i_wdata(mem_wd),
        .o_rdata(mem_q)
    );

    // Vector bytes read from the register, not from RAM
    always_comb begin
        if (r_ra == VEC_LO) begin
            rd_val = r_rv[7:0];
        end else if (r_ra == VEC_HI) begin
            rd_val = r_rv[15:8];
        end else begin
            rd_val = mem_q;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign mem_we  = wr_req && (mem_addr != PRINT_ADDR);

    // Sequencer: one RAM access per cycle
    always_comb begin
        n_state = r_state;
        n_pc = r_pc; n_a = r_a; n_x = r_x; n_y = r_y; n_sp = r_sp; n_p = r_p;
        n_op = r_op; n_b1 = r_b1; n_b2 = r_b2; n_lo = r_lo; n_wd = r_wd;
        n_zp = r_zp; n_rb = r_rb; n_unk = r_unk; n_ea = r_ea; n_ra = r_ra;
        wr_req = 1'b0;
        mem_addr = r_ea;
        mem_wd = r_wd;
        d = f_dec(r_op);
        ab = {r_b2, r_b1};
        t_ret = r_pc + 16'd2;
        ea = ab;
        v = rd_val;
        res = 8'h00;
        src = r_a;
        case (d.rsel)
            R_X: src = r_x;
            R_Y: src = r_y;
            default: src = r_a;
        endcase

        case (r_state)
            S_IDLE: begin
                mem_addr = i_mem_address;
                mem_wd = i_mem_data;
                if (i_valid) begin
                    n_rb = 8'h00;
                    n_unk = 1'b0;
                    case (i_req_type)
                        REQ_LOAD: begin
                            wr_req = 1'b1;
                            n_state = S_OUT;
                        end
                        REQ_EXEC: begin
                            mem_addr = r_pc;
                            n_ra = r_pc;
                            n_state = S_B1;
                        end
                        REQ_RESET: begin
                            n_pc = r_rv; n_a = 8'h00; n_x = 8'h00; n_y = 8'h00;
                            n_sp = SP_RESET; n_p = 8'h00;
                            n_state = S_OUT;
                        end
                        default: begin
                            n_ra = i_mem_address;
                            n_state = S_RDR;
                        end
                    endcase
                end
            end
            S_RDR: begin
                n_rb = rd_val;
                n_state = S_OUT;
            end
            S_B1: begin
                n_op = rd_val;
                mem_addr = r_pc + 16'd1;
                n_ra = mem_addr;
                n_state = S_B2;
            end
            S_B2: begin
                n_b1 = rd_val;
                mem_addr = r_pc + 16'd2;
                n_ra = mem_addr;
                n_state = S_DEC;
            end
            S_DEC: begin
                n_b2 = rd_val;
                n_state = S_EX;
            end
            S_EX: begin
                n_state = S_OUT;
                n_pc = r_pc + {14'd0, d.len};
                case (d.cls)
                    C_UNK: n_unk = 1'b1;
                    C_BRK: n_p = r_p | F_B;
                    C_IMM: begin
                        res = d.is_and ? (r_a & r_b1) : r_b1;
                        n_p = f_nz(r_p, res);
                        case (d.rsel)
                            R_X: n_x = res;
                            R_Y: n_y = res;
                            default: n_a = res;
                        endcase
                    end
                    C_TR: begin
                        case (r_op)
                            OP_TAX: begin n_x = r_a; n_p = f_nz(r_p, r_a); end
                            OP_TAY: begin n_y = r_a; n_p = f_nz(r_p, r_a); end
                            OP_TSX: begin n_x = r_sp; n_p = f_nz(r_p, r_sp); end
                            OP_TXA: begin n_a = r_x; n_p = f_nz(r_p, r_x); end
                            OP_TXS: n_sp = r_x;
                            OP_TYA: begin n_a = r_y; n_p = f_nz(r_p, r_y); end
                            OP_ASLA: begin
                                res = {r_a[6:0], 1'b0};
                                n_a = res;
                                n_p = f_nz(r_p, res);
                                n_p[FC] = r_a[7];
                            end
                            OP_LSRA: begin
                                res = {1'b0, r_a[7:1]};
                                n_a = res;
                                n_p = f_nz(r_p, res);
                                n_p[FC] = r_a[0];
                            end
                            default: ;
                        endcase
                    end
                    C_LD, C_ST, C_RMW: begin
                        case (d.mode)
                            M_ZP:  ea = {8'h00, r_b1};
                            M_ZPX: ea = {8'h00, r_b1 + r_x};
                            M_ABX: ea = ab + {8'h00, r_x};
                            M_ABY: ea = ab + {8'h00, r_y};
                            default: ea = ab;
                        endcase
                        if (d.mode == M_IZX || d.mode == M_IZY) begin
                            n_zp = (d.mode == M_IZX) ? (r_b1 + r_x) : r_b1;
                            mem_addr = {8'h00, n_zp};
                            n_ra = mem_addr;
                            n_state = S_PL;
                        end else begin
                            n_ea = ea;
                            n_state = S_ACC;
                        end
                    end
                    C_PUSH: begin
                        mem_addr = {STACK_PAGE, r_sp};
                        mem_wd = r_op[6] ? r_a : (r_p | F_PUSH);
                        wr_req = 1'b1;
                        n_sp = r_sp - 8'd1;
                    end
                    C_PULL: begin
                        n_sp = r_sp + 8'd1;
                        mem_addr = {STACK_PAGE, n_sp};
                        n_ra = mem_addr;
                        n_state = S_POP1;
                    end
                    C_JMP: n_pc = ab;
                    C_JMPI: begin
                        n_pc = r_pc;
                        mem_addr = ab;
                        n_ra = ab;
                        n_state = S_JI1;
                    end
                    C_JSR: begin
                        n_pc = r_pc;
                        mem_addr = {STACK_PAGE, r_sp};
                        mem_wd = t_ret[15:8];
                        wr_req = 1'b1;
                        n_sp = r_sp - 8'd1;
                        n_state = S_JSR2;
                    end
                    default: ;
                endcase
            end
            S_PL: begin
                n_lo = rd_val;
                mem_addr = {8'h00, r_zp + 8'd1};
                n_ra = mem_addr;
                n_state = S_PH;
            end
            S_PH: begin
                n_ea = {rd_val, r_lo} + ((d.mode == M_IZY) ? {8'h00, r_y} : 16'h0000);
                n_state = S_ACC;
            end
            S_ACC: begin
                mem_addr = r_ea;
                if (d.cls == C_ST) begin
                    mem_wd = src;
                    wr_req = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_ra = r_ea;
                    n_state = S_MEM;
                end
            end
            S_MEM: begin
                if (d.cls == C_RMW) begin
                    res = r_op[6] ? {1'b0, v[7:1]} : {v[6:0], 1'b0};
                    n_p = f_nz(r_p, res);
                    n_p[FC] = r_op[6] ? v[0] : v[7];
                    n_wd = res;
                    n_state = S_WB;
                end else begin
                    res = d.is_and ? (r_a & v) : v;
                    n_p = f_nz(r_p, res);
                    case (d.rsel)
                        R_X: n_x = res;
                        R_Y: n_y = res;
                        default: n_a = res;
                    endcase
                    n_state = S_OUT;
                end
            end
            S_WB: begin
                mem_addr = r_ea;
                mem_wd = r_wd;
                wr_req = 1'b1;
                n_state = S_OUT;
            end
            S_POP1: begin
                n_state = S_OUT;
                case (r_op)
                    OP_PLA: begin n_a = v; n_p = f_nz(r_p, v); end
                    OP_PLP: n_p = (v & F_PULLMK) | (r_p & F_PUSH);
                    default: begin
                        if (r_op == OP_RTI) begin
                            n_p = (v & F_PULLMK) | (r_p & F_PUSH);
                        end else begin
                            n_lo = v;
                        end
                        n_sp = r_sp + 8'd1;
                        mem_addr = {STACK_PAGE, n_sp};
                        n_ra = mem_addr;
                        n_state = S_POP2;
                    end
                endcase
            end
            S_POP2: begin
                if (r_op == OP_RTS) begin
                    n_pc = {v, r_lo} + 16'd1;
                    n_state = S_OUT;
                end else begin
                    n_lo = v;
                    n_sp = r_sp + 8'd1;
                    mem_addr = {STACK_PAGE, n_sp};
                    n_ra = mem_addr;
                    n_state = S_POP3;
                end
            end
            S_POP3: begin
                n_pc = {v, r_lo};
                n_state = S_OUT;
            end
            S_JI1: begin
                n_lo = rd_val;
                mem_addr = ab + 16'd1;
                n_ra = mem_addr;
                n_state = S_JI2;
            end
            S_JI2: begin
                n_pc = {rd_val, r_lo};
                n_state = S_OUT;
            end
            S_JSR2: begin
                mem_addr = {STACK_PAGE, r_sp};
                mem_wd = t_ret[7:0];
                wr_req = 1'b1;
                n_sp = r_sp - 8'd1;
                n_pc = ab;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ov || i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control and architectural registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rv <= RV_RESET;
            r_pc <= RV_RESET;
            r_a <= 8'h00; r_x <= 8'h00; r_y <= 8'h00;
            r_sp <= SP_RESET; r_p <= 8'h00;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_rv <= i_cfg_data;
            end
            r_pc <= n_pc; r_a <= n_a; r_x <= n_x; r_y <= n_y;
            r_sp <= n_sp; r_p <= n_p;
            if (r_state == S_OUT && (!r_ov || i_ready)) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_b1 <= n_b1; r_b2 <= n_b2; r_lo <= n_lo; r_wd <= n_wd;
        r_zp <= n_zp; r_rb <= n_rb; r_unk <= n_unk; r_ea <= n_ea; r_ra <= n_ra;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_ov || i_ready)) begin
            o_pc_out     <= r_pc;
            o_acc_out    <= r_a;
            o_x_out      <= r_x;
            o_y_out      <= r_y;
            o_sp_out     <= r_sp;
            o_status_out <= r_p | F_PUSH & 8'h20;
            o_read_byte  <= r_rb;
            o_unknown_op <= r_unk;
        end
    end

    assign o_valid = r_ov;

    // Checks
    a_no_print_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> mem_addr != PRINT_ADDR) else $error("write to print port");

    a_reset_sp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_req_type == REQ_RESET) |=> (r_sp == SP_RESET))
        else $error("reset request did not restore stack pointer");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == S_OUT)
        else $error("result registered outside output state");

endmodule

[bench/cpu6502_tb_pkg.sv]
// Testbench package: 6502 opcodes of the executed subset.
`timescale 1ns / 1ps
package cpu65_tb_pkg;

    typedef enum logic [7:0] {
        BRK     = 8'h00, PHP     = 8'h08, ASL_ZP  = 8'h06, ASL_A   = 8'h0A,
        ASL_ABS = 8'h0E, JSR     = 8'h20, AND_ZP  = 8'h25, PLP     = 8'h28,
        AND_IMM = 8'h29, AND_ABS = 8'h2D, RTI     = 8'h40, LSR_ZP  = 8'h46,
        PHA     = 8'h48, LSR_A   = 8'h4A, JMP_ABS = 8'h4C, LSR_ABS = 8'h4E,
        RTS     = 8'h60, PLA     = 8'h68, JMP_IND = 8'h6C, STA_IZX = 8'h81,
        STY_ZP  = 8'h84, STA_ZP  = 8'h85, STX_ZP  = 8'h86, TXA     = 8'h8A,
        STY_ABS = 8'h8C, STA_ABS = 8'h8D, STX_ABS = 8'h8E, STA_IZY = 8'h91,
        STA_ZPX = 8'h95, TYA     = 8'h98, TXS     = 8'h9A, LDY_IMM = 8'hA0,
        LDA_IZX = 8'hA1, LDX_IMM = 8'hA2, LDY_ZP  = 8'hA4, LDA_ZP  = 8'hA5,
        LDX_ZP  = 8'hA6, TAY     = 8'hA8, LDA_IMM = 8'hA9, TAX     = 8'hAA,
        LDY_ABS = 8'hAC, LDA_ABS = 8'hAD, LDX_ABS = 8'hAE, LDA_IZY = 8'hB1,
        LDA_ZPX = 8'hB5, LDA_ABY = 8'hB9, TSX     = 8'hBA, LDA_ABX = 8'hBD,
        NOP     = 8'hEA
    } opcode_e;

    // Bytes that are not in the subset
    localparam logic [7:0] OPC_UNDEFINED = 8'h02;

endpackage

[bench/cpu6502_exec_checker.sv]
// Checker: predicts every result item of the 6502 executor and compares it with the DUT.
`timescale 1ns / 1ps
module cpu6502_exec_checker
    import cpu65_pkg::*;
    import cpu65_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [15:0] mem_address,
    input  logic [7:0]  mem_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] pc_out,
    input  logic [7:0]  acc_out,
    input  logic [7:0]  x_out,
    input  logic [7:0]  y_out,
    input  logic [7:0]  sp_out,
    input  logic [7:0]  status_out,
    input  logic [7:0]  read_byte,
    input  logic        unknown_op,
    output int          fail_count,
    output int          items_in,
    output int          pending
);

    typedef struct packed {
        logic [15:0] pc;
        logic [7:0]  a, x, y, sp, p;
    } cpu_regs_t;

    typedef struct packed {
        logic [15:0] pc;
        logic [7:0]  a, x, y, sp, status, rbyte;
        logic        unk;
    } cpu_result_t;

    logic [7:0]  mem [0:65535];
    bit          written [0:65535];
    cpu_regs_t   regs;
    logic [15:0] vec;
    cpu_result_t results_due[$];
    bit          bad_read;

    initial begin
        fail_count = 0;
        items_in   = 0;
        pending    = 0;
    end

    // Memory read as the core sees it; vector bytes come from the register.
    // Flags any byte that was never loaded.
    function automatic logic [7:0] peek(input logic [15:0] a);
        if (a == VEC_LO) return vec[7:0];
        if (a == VEC_HI) return vec[15:8];
        if (!written[a]) bad_read = 1'b1;
        return mem[a];
    endfunction

    function automatic void poke(input logic [15:0] a, input logic [7:0] v, input bit commit);
        if (commit && a != PRINT_ADDR) begin
            mem[a]     = v;
            written[a] = 1'b1;
        end
    endfunction

    function automatic logic [7:0] nz(input logic [7:0] p, input logic [7:0] v);
        return {v[7], p[6:2], v == 8'h00, p[0]};
    endfunction

    // Zero-page pointer, high byte wraps inside page zero
    function automatic logic [15:0] zp_word(input logic [7:0] z);
        logic [7:0] z1;
        z1 = z + 8'd1;
        return {peek({8'h00, z1}), peek({8'h00, z})};
    endfunction

    function automatic void push(inout cpu_regs_t r, input logic [7:0] v, input bit commit);
        poke({STACK_PAGE, r.sp}, v, commit);
        r.sp = r.sp - 8'd1;
    endfunction

    function automatic logic [7:0] pull(inout cpu_regs_t r);
        r.sp = r.sp + 8'd1;
        return peek({STACK_PAGE, r.sp});
    endfunction

    function automatic cpu_regs_t regs_after_reset();
        cpu_regs_t r;
        r.pc = vec;
        r.a  = 8'h00;
        r.x  = 8'h00;
        r.y  = 8'h00;
        r.sp = SP_RESET;
        r.p  = 8'h00;
        return r;
    endfunction

    // One instruction; memory is only written when commit is set
    function automatic bit run_instr(inout cpu_regs_t r, input bit commit);
        logic [7:0]  op, b1, b2, zx, v, lo, hi;
        logic [15:0] ab, nxt, t, pc2, pc3;
        bit          unk;
        op  = peek(r.pc);
        b1  = peek(r.pc + 16'd1);
        b2  = peek(r.pc + 16'd2);
        ab  = {b2, b1};
        nxt = r.pc + 16'd1;
        pc2 = r.pc + 16'd2;
        pc3 = r.pc + 16'd3;
        zx  = b1 + r.x;
        unk = 1'b0;
        case (op)
            BRK:     r.p = r.p | F_B;
            // loads
            LDA_IMM: begin r.a = b1; r.p = nz(r.p, r.a); nxt = pc2; end
            LDA_ZP:  begin r.a = peek({8'h00, b1}); r.p = nz(r.p, r.a); nxt = pc2; end
            LDA_ZPX: begin r.a = peek({8'h00, zx}); r.p = nz(r.p, r.a); nxt = pc2; end
            LDA_IZX: begin r.a = peek(zp_word(zx)); r.p = nz(r.p, r.a); nxt = pc2; end
            LDA_IZY: begin
                r.a = peek(zp_word(b1) + {8'h00, r.y}); r.p = nz(r.p, r.a); nxt = pc2;
            end
            LDA_ABS: begin r.a = peek(ab); r.p = nz(r.p, r.a); nxt = pc3; end
            LDA_ABX: begin r.a = peek(ab + {8'h00, r.x}); r.p = nz(r.p, r.a); nxt = pc3; end
            LDA_ABY: begin r.a = peek(ab + {8'h00, r.y}); r.p = nz(r.p, r.a); nxt = pc3; end
            LDX_IMM: begin r.x = b1; r.p = nz(r.p, r.x); nxt = pc2; end
            LDX_ZP:  begin r.x = peek({8'h00, b1}); r.p = nz(r.p, r.x); nxt = pc2; end
            LDX_ABS: begin r.x = peek(ab); r.p = nz(r.p, r.x); nxt = pc3; end
            LDY_IMM: begin r.y = b1; r.p = nz(r.p, r.y); nxt = pc2; end
            LDY_ZP:  begin r.y = peek({8'h00, b1}); r.p = nz(r.p, r.y); nxt = pc2; end
            LDY_ABS: begin r.y = peek(ab); r.p = nz(r.p, r.y); nxt = pc3; end
            // stores
            STA_ZP:  begin poke({8'h00, b1}, r.a, commit); nxt = pc2; end
            STA_ZPX: begin poke({8'h00, zx}, r.a, commit); nxt = pc2; end
            STA_IZX: begin poke(zp_word(zx), r.a, commit); nxt = pc2; end
            STA_IZY: begin poke(zp_word(b1) + {8'h00, r.y}, r.a, commit); nxt = pc2; end
            STA_ABS: begin poke(ab, r.a, commit); nxt = pc3; end
            STX_ZP:  begin poke({8'h00, b1}, r.x, commit); nxt = pc2; end
            STX_ABS: begin poke(ab, r.x, commit); nxt = pc3; end
            STY_ZP:  begin poke({8'h00, b1}, r.y, commit); nxt = pc2; end
            STY_ABS: begin poke(ab, r.y, commit); nxt = pc3; end
            // transfers
            TAX: begin r.x = r.a; r.p = nz(r.p, r.x); end
            TAY: begin r.y = r.a; r.p = nz(r.p, r.y); end
            TSX: begin r.x = r.sp; r.p = nz(r.p, r.x); end
            TXA: begin r.a = r.x; r.p = nz(r.p, r.a); end
            TXS: r.sp = r.x;
            TYA: begin r.a = r.y; r.p = nz(r.p, r.a); end
            // stack
            PHA: push(r, r.a, commit);
            PHP: push(r, r.p | 8'h30, commit);
            PLA: begin r.a = pull(r); r.p = nz(r.p, r.a); end
            PLP: begin v = pull(r); r.p = (v & 8'hCF) | (r.p & 8'h30); end
            // shifts: accumulator and memory forms
            ASL_A: begin r.p[FC] = r.a[7]; r.a = r.a << 1; r.p = nz(r.p, r.a); end
            LSR_A: begin r.p[FC] = r.a[0]; r.a = r.a >> 1; r.p = nz(r.p, r.a); end
            ASL_ZP, ASL_ABS, LSR_ZP, LSR_ABS: begin
                t = (op == ASL_ZP || op == LSR_ZP) ? {8'h00, b1} : ab;
                nxt = (op == ASL_ZP || op == LSR_ZP) ? pc2 : pc3;
                v = peek(t);
                if (op == ASL_ZP || op == ASL_ABS) begin
                    r.p[FC] = v[7];
                    v = v << 1;
                end else begin
                    r.p[FC] = v[0];
                    v = v >> 1;
                end
                r.p = nz(r.p, v);
                poke(t, v, commit);
            end
            // AND
            AND_IMM: begin r.a = r.a & b1; r.p = nz(r.p, r.a); nxt = pc2; end
            AND_ZP:  begin r.a = r.a & peek({8'h00, b1}); r.p = nz(r.p, r.a); nxt = pc2; end
            AND_ABS: begin r.a = r.a & peek(ab); r.p = nz(r.p, r.a); nxt = pc3; end
            // control flow; indirect JMP has no page wrap
            JMP_ABS: nxt = ab;
            JMP_IND: begin lo = peek(ab); hi = peek(ab + 16'd1); nxt = {hi, lo}; end
            JSR: begin
                push(r, pc2[15:8], commit);
                push(r, pc2[7:0], commit);
                nxt = ab;
            end
            RTS: begin lo = pull(r); hi = pull(r); nxt = {hi, lo} + 16'd1; end
            RTI: begin
                v = pull(r);
                r.p = (v & 8'hCF) | (r.p & 8'h30);
                lo = pull(r);
                hi = pull(r);
                nxt = {hi, lo};
            end
            NOP: ;
            default: unk = 1'b1;
        endcase
        r.pc = nxt;
        return unk;
    endfunction

    function automatic cpu_result_t apply_item(input logic [1:0] req, input logic [15:0] addr,
                                               input logic [7:0] data);
        cpu_result_t res;
        logic [7:0]  rb;
        bit          unk;
        rb  = 8'h00;
        unk = 1'b0;
        case (req)
            REQ_LOAD:  poke(addr, data, 1'b1);
            REQ_EXEC:  unk = run_instr(regs, 1'b1);
            REQ_RESET: regs = regs_after_reset();
            REQ_READ:  rb = peek(addr);
            default: ;
        endcase
        res.pc     = regs.pc;
        res.a      = regs.a;
        res.x      = regs.x;
        res.y      = regs.y;
        res.sp     = regs.sp;
        res.status = regs.p | 8'h20;
        res.rbyte  = rb;
        res.unk    = unk;
        return res;
    endfunction

    // Queries for the stimulus side
    function automatic logic [15:0] cur_pc();
        return regs.pc;
    endfunction

    // True when the instruction at pc reads only bytes that were loaded
    function automatic bit exec_safe();
        cpu_regs_t scratch;
        scratch  = regs;
        bad_read = 1'b0;
        void'(run_instr(scratch, 1'b0));
        return !bad_read;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Predict on input accept, compare on output accept
    always @(posedge clk) begin
        cpu_result_t want;
        if (!rst_n) begin
            vec  = RV_RESET;
            regs = regs_after_reset();
            results_due.delete();
        end else begin
            if (cfg_we) vec = cfg_data;
            if (in_valid && in_ready) begin
                results_due.push_back(apply_item(req_type, mem_address, mem_data));
                items_in++;
            end
            if (out_valid && out_ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result item with nothing expected, pc %h", $time, pc_out);
                    fail_count++;
                end else begin
                    want = results_due.pop_front();
                    check_field("pc", want.pc, pc_out);
                    check_field("acc", {8'h00, want.a}, {8'h00, acc_out});
                    check_field("x", {8'h00, want.x}, {8'h00, x_out});
                    check_field("y", {8'h00, want.y}, {8'h00, y_out});
                    check_field("sp", {8'h00, want.sp}, {8'h00, sp_out});
                    check_field("status", {8'h00, want.status}, {8'h00, status_out});
                    check_field("read_byte", {8'h00, want.rbyte}, {8'h00, read_byte});
                    check_field("unknown_op", {15'h0, want.unk}, {15'h0, unknown_op});
                end
            end
        end
        pending = results_due.size();
    end

endmodule

[bench/tb_cpu6502_subset_executor.sv]
// Testbench top: stimulus, idling and verdict for the 6502 subset executor.
`timescale 1ns / 1ps
module tb_cpu6502_subset_executor;
    import cpu65_pkg::*;
    import cpu65_tb_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS  = 480;
    localparam int HOLD_CYCLES  = 400;
    localparam int FILL_BYTES   = 512;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = 16'h0000;
    logic        i_valid = 1'b0;
    logic        i_ready = 1'b0;
    logic [1:0]  i_req_type = REQ_LOAD;
    logic [15:0] i_mem_address = 16'h0000;
    logic [7:0]  i_mem_data = 8'h00;
    logic        o_ready, o_valid, o_unknown_op;
    logic [15:0] o_pc_out;
    logic [7:0]  o_acc_out, o_x_out, o_y_out, o_sp_out, o_status_out, o_read_byte;

    int fail_count, items_in, pending;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int n_sent = 0;
    int n_exec = 0;
    int stall = 0;
    opcode_e op_pool[$];

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    cpu6502_subset_executor uut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data, .i_valid, .o_ready,
        .i_req_type, .i_mem_address, .i_mem_data, .o_valid, .i_ready,
        .o_pc_out, .o_acc_out, .o_x_out, .o_y_out, .o_sp_out, .o_status_out,
        .o_read_byte, .o_unknown_op
    );

    cpu6502_exec_checker chk (
        .clk(i_clk), .rst_n(i_rst_n), .cfg_we(i_cfg_we), .cfg_data(i_cfg_data),
        .in_valid(i_valid), .in_ready(o_ready), .req_type(i_req_type),
        .mem_address(i_mem_address), .mem_data(i_mem_data),
        .out_valid(o_valid), .out_ready(i_ready), .pc_out(o_pc_out),
        .acc_out(o_acc_out), .x_out(o_x_out), .y_out(o_y_out), .sp_out(o_sp_out),
        .status_out(o_status_out), .read_byte(o_read_byte), .unknown_op(o_unknown_op),
        .fail_count, .items_in, .pending
    );

    // Result side: random stalls plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog on either channel making progress
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                stall <= 0;
            end else if (stall == STALL_LIMIT) begin
                $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end else begin
                stall <= stall + 1;
            end
        end
    end

    // High operand byte, mostly pointing into the loaded pages
    function automatic logic [7:0] rand_hi();
        if ($urandom_range(3) == 0) return 8'($urandom);
        return 8'($urandom_range(1));
    endfunction

    // Offer one item and hold it until accepted; may idle afterwards
    task automatic send(input logic [1:0] req, input logic [15:0] addr, input logic [7:0] data);
        i_valid       <= 1'b1;
        i_req_type    <= req;
        i_mem_address <= addr;
        i_mem_data    <= data;
        do @(posedge i_clk); while (!o_ready);
        n_sent++;
        if (req == REQ_EXEC) n_exec++;
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every result has come back
    task automatic settle();
        i_valid <= 1'b0;
        wait (items_in == n_sent && pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_vector(input logic [15:0] v);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        send(REQ_RESET, 16'($urandom), 8'($urandom));
    endtask

    // Execute at pc unless it would read a byte that was never loaded
    task automatic exec_or_reset();
        wait (items_in == n_sent);
        if (chk.exec_safe()) send(REQ_EXEC, 16'($urandom), 8'($urandom));
        else send(REQ_RESET, 16'($urandom), 8'($urandom));
    endtask

    // Place one instruction at the current pc, then run it
    task automatic place_and_run(input logic [7:0] op, input logic [7:0] b1, input logic [7:0] b2);
        logic [15:0] pc;
        wait (items_in == n_sent);
        pc = chk.cur_pc();
        send(REQ_LOAD, pc, op);
        send(REQ_LOAD, pc + 16'd1, b1);
        send(REQ_LOAD, pc + 16'd2, b2);
        exec_or_reset();
    endtask

    task automatic random_phase(input bit with_hold, input bit with_pause);
        int target, roll;
        bit mid_done;
        logic [15:0] a;
        target = n_sent + PHASE_ITEMS;
        mid_done = 1'b0;
        while (n_sent < target) begin
            if (!mid_done && n_sent >= target - PHASE_ITEMS / 2) begin
                mid_done = 1'b1;
                if (with_hold) hold_request = HOLD_CYCLES;
                if (with_pause) settle();
            end
            roll = $urandom_range(99);
            if (roll < 72) begin
                place_and_run(op_pool[$urandom_range(op_pool.size() - 1)],
                              8'($urandom), rand_hi());
            end else if (roll < 80) begin
                place_and_run(8'($urandom), 8'($urandom), rand_hi());
            end else begin
                // noise: any request with random content
                a = 16'($urandom);
                case ($urandom_range(3))
                    0: send(REQ_LOAD, a, 8'($urandom));
                    1: exec_or_reset();
                    2: send(REQ_RESET, a, 8'($urandom));
                    default: send(REQ_READ, {7'h00, a[8:0]}, 8'($urandom));
                endcase
            end
        end
    endtask

    initial begin
        opcode_e e;
        logic [15:0] v;
        e = e.first();
        forever begin
            op_pool.push_back(e);
            if (e == e.last()) break;
            e = e.next();
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Load zero page and the stack page so pointers and pulls read loaded bytes
        for (int a = 0; a < FILL_BYTES; a++) begin
            send(REQ_LOAD, 16'(a), 8'($urandom));
        end

        // Directed: special addresses and a few corner instructions
        set_vector(16'h0000);
        send(REQ_LOAD, PRINT_ADDR, 8'hA5);
        send(REQ_LOAD, VEC_LO, 8'h3C);
        send(REQ_READ, VEC_LO, 8'h00);
        send(REQ_READ, VEC_HI, 8'h00);
        place_and_run(LDA_IMM, 8'h81, 8'h00);
        place_and_run(LSR_A, 8'h00, 8'h00);
        place_and_run(PHP, 8'h00, 8'h00);
        place_and_run(PLP, 8'h00, 8'h00);
        place_and_run(BRK, 8'h00, 8'h00);
        place_and_run(OPC_UNDEFINED, 8'hFF, 8'hFF);
        place_and_run(JMP_IND, 8'hFF, 8'h00);

        // Random phases, one reset vector each
        tx_idle_pct = 9;
        rx_idle_pct = 54;
        set_vector(16'hFFFF);
        random_phase(1'b1, 1'b0);

        tx_idle_pct = 54;
        rx_idle_pct = 9;
        do v = 16'($urandom); while (v >= 16'hFFF9 && v <= PRINT_ADDR);
        set_vector(v);
        random_phase(1'b0, 1'b1);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_vector(RV_RESET);
        random_phase(1'b0, 1'b0);

        settle();
        $display("Covered %0d items after loading pages zero and one, %0d executed instructions,",
                 n_sent, n_exec);
        $display("four reset vectors and three sender/receiver idling mixes.");
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
